// File: rtl/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

  // UTF-16 code units and code point limits.
  localparam logic [15:0] UNIT_REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] UNIT_HIGH_BASE   = 16'hD800;
  localparam logic [15:0] UNIT_LOW_BASE    = 16'hDC00;
  localparam logic [20:0] CP_SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] CP_SURR_LAST     = 21'h00DFFF;
  localparam logic [20:0] CP_PLANE1        = 21'h010000;
  localparam logic [20:0] CP_MAX           = 21'h10FFFF;
  localparam logic [20:0] CP_MIN_LEN2      = 21'h000080;
  localparam logic [20:0] CP_MIN_LEN3      = 21'h000800;

  // Sequence lengths.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Command queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One command per input byte that produces output: a run of replacement
  // units first, then up to two tail units (a plain unit or a surrogate pair).
  typedef struct packed {
    logic [15:0] unit1;
    logic [15:0] unit0;
    logic [1:0]  tail_cnt;
    logic [2:0]  rep_cnt;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/u8u16_front.sv
// Front end: takes UTF-8 bytes, tracks the pending sequence and issues commands.
`default_nettype none

module u8u16_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] text_byte
  input  wire logic              in_tlast,   // end_of_text
  input  wire logic              q_full,
  output logic                   q_push,
  output u8u16_pkg::cmd_t        q_cmd
);

  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [2:0]  rcv_r, rcv_nxt;
  logic [20:0] bits_r, bits_nxt;

  logic [2:0]  reps;
  logic        tail_en;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [20:0] gath;
  logic [2:0]  rcv_inc;
  logic        lead_now;
  logic        accept;

  // Range checks on a completed sequence: overlong, surrogate, out of range.
  function automatic logic value_ok(input logic [20:0] v, input logic [2:0] len);
    logic ok;
    ok = 1'b0;
    if (len == u8u16_pkg::SEQ_LEN2) begin
      ok = (v >= u8u16_pkg::CP_MIN_LEN2);
    end else if (len == u8u16_pkg::SEQ_LEN3) begin
      ok = (v >= u8u16_pkg::CP_MIN_LEN3) &&
           !((v >= u8u16_pkg::CP_SURR_FIRST) && (v <= u8u16_pkg::CP_SURR_LAST));
    end else begin
      ok = (v >= u8u16_pkg::CP_PLANE1) && (v <= u8u16_pkg::CP_MAX);
    end
    return ok;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Decode the byte against the pending sequence.
  always_comb begin
    exp_len_nxt = exp_len_r;
    rcv_nxt     = rcv_r;
    bits_nxt    = bits_r;
    reps        = 3'd0;
    tail_en     = 1'b0;
    cp          = 21'd0;
    lead_now    = 1'b0;
    gath        = {bits_r[14:0], in_tdata[5:0]};
    rcv_inc     = 3'(rcv_r + 3'd1);

    if (exp_len_r != u8u16_pkg::SEQ_NONE) begin
      if (in_tdata[7:6] == 2'b10) begin
        if (rcv_inc >= exp_len_r) begin
          if (value_ok(gath, exp_len_r)) begin
            tail_en = 1'b1;
            cp      = gath;
          end else begin
            reps = exp_len_r;
          end
          exp_len_nxt = u8u16_pkg::SEQ_NONE;
          rcv_nxt     = 3'd0;
          bits_nxt    = 21'd0;
        end else begin
          rcv_nxt  = rcv_inc;
          bits_nxt = gath;
        end
      end else begin
        // The sequence breaks: replace what was held, then restart here.
        reps        = rcv_r;
        exp_len_nxt = u8u16_pkg::SEQ_NONE;
        rcv_nxt     = 3'd0;
        bits_nxt    = 21'd0;
        lead_now    = 1'b1;
      end
    end else begin
      lead_now = 1'b1;
    end

    // Lead byte handling.
    if (lead_now) begin
      if (in_tdata[7] == 1'b0) begin
        tail_en = 1'b1;
        cp      = {13'd0, in_tdata};
      end else if (in_tdata[7:5] == 3'b110) begin
        exp_len_nxt = u8u16_pkg::SEQ_LEN2;
        rcv_nxt     = 3'd1;
        bits_nxt    = {16'd0, in_tdata[4:0]};
      end else if (in_tdata[7:4] == 4'b1110) begin
        exp_len_nxt = u8u16_pkg::SEQ_LEN3;
        rcv_nxt     = 3'd1;
        bits_nxt    = {17'd0, in_tdata[3:0]};
      end else if (in_tdata[7:3] == 5'b11110) begin
        exp_len_nxt = u8u16_pkg::SEQ_LEN4;
        rcv_nxt     = 3'd1;
        bits_nxt    = {18'd0, in_tdata[2:0]};
      end else begin
        reps = 3'(reps + 3'd1);
      end
    end

    // A sequence cut off by the end of the text is flushed as replacements.
    if (in_tlast && (exp_len_nxt != u8u16_pkg::SEQ_NONE)) begin
      reps        = 3'(reps + rcv_nxt);
      exp_len_nxt = u8u16_pkg::SEQ_NONE;
      rcv_nxt     = 3'd0;
      bits_nxt    = 21'd0;
    end
  end

  // Tail units: a plain unit or a surrogate pair.
  assign cp_off = 21'(cp - u8u16_pkg::CP_PLANE1);

  always_comb begin
    q_cmd.rep_cnt = reps;
    if (!tail_en) begin
      q_cmd.tail_cnt = 2'd0;
      q_cmd.unit0    = cp[15:0];
      q_cmd.unit1    = cp[15:0];
    end else if (cp[20:16] != 5'd0) begin
      q_cmd.tail_cnt = 2'd2;
      q_cmd.unit0    = u8u16_pkg::UNIT_HIGH_BASE | {6'd0, cp_off[19:10]};
      q_cmd.unit1    = u8u16_pkg::UNIT_LOW_BASE | {6'd0, cp_off[9:0]};
    end else begin
      q_cmd.tail_cnt = 2'd1;
      q_cmd.unit0    = cp[15:0];
      q_cmd.unit1    = cp[15:0];
    end
  end

  // Only bytes that produce output enter the queue.
  assign q_push = accept && ((reps != 3'd0) || tail_en);

  // Pending sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= u8u16_pkg::SEQ_NONE;
      rcv_r     <= 3'd0;
      bits_r    <= 21'd0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      rcv_r     <= rcv_nxt;
      bits_r    <= bits_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8u16_queue.sv
// Command queue between the front end and the unit serialiser.
`default_nettype none

module u8u16_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u8u16_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output u8u16_pkg::cmd_t      head_cmd
);

  u8u16_pkg::cmd_t                  mem_r [u8u16_pkg::QUEUE_DEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [u8u16_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [u8u16_pkg::QCNT_W-1:0]     cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (cnt_r == u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= u8u16_pkg::QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= u8u16_pkg::QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= u8u16_pkg::QCNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= u8u16_pkg::QCNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8u16_back.sv
// Back end: expands queued commands into UTF-16 units, one per transfer.
`default_nettype none

module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire u8u16_pkg::cmd_t q_head,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [15:0]          out_tdata,   // [15:0] code_unit
  output logic                 out_tlast    // last_of_run
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic [15:0] data_r;
  logic        last_r;
  logic [2:0]  total;
  logic [2:0]  tidx;
  logic        unit_last;
  logic [15:0] unit_val;
  logic        load;

  // Select the unit at the current position within the head command.
  always_comb begin
    total     = 3'(q_head.rep_cnt + {1'b0, q_head.tail_cnt});
    tidx      = 3'({1'b0, idx_r} - q_head.rep_cnt);
    unit_last = (3'({1'b0, idx_r} + 3'd1) == total);
    if ({1'b0, idx_r} < q_head.rep_cnt) begin
      unit_val = u8u16_pkg::UNIT_REPLACEMENT;
    end else if (tidx[0]) begin
      unit_val = q_head.unit1;
    end else begin
      unit_val = q_head.unit0;
    end
  end

  assign load    = q_not_empty && (!valid_r || out_tready);
  assign q_pop   = load && unit_last;
  assign idx_nxt = unit_last ? 2'd0 : 2'(idx_r + 2'd1);

  // Output register and position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= unit_val;
      last_r <= unit_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// File: rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder: a byte's command is queued, then its units pass through the output register.
// Input takes one byte per cycle while the 4-entry command queue has room.
// Output gives one code unit per cycle while out_tready is high; a byte yields 0 to 4
// units, so a sustained run of multi-unit bytes is paced by the output serialiser.
// Synchronous active-low reset clears the pending sequence, queue and output.
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] code_unit
  output logic             out_tlast   // last_of_run
);

  u8u16_pkg::cmd_t push_cmd;
  u8u16_pkg::cmd_t head_cmd;
  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;

  // Byte decoding and sequence tracking.
  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  // Decoupling queue.
  u8u16_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  // Unit serialiser.
  u8u16_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_head      (head_cmd),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire
